/* sv/euler_to_quaternion_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the Euler to quaternion unit
// Concurrent checks compiled in simulation, empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef EULER_TO_QUATERNION_UNIT_MACROS_SVH
`define EULER_TO_QUATERNION_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// check held off while reset is high
`define EQC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// check that holds on every edge
`define EQC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define EQC_ASSERT(lbl, prop, msg)
`define EQC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* sv/eqc_pkg.sv */
// ----------------------------------------------------------------------------
// eqc_pkg
// Widths, constants and elaboration-time helpers of the Euler to quaternion unit.
// ----------------------------------------------------------------------------
package eqc_pkg;

   localparam int ANGLE_FRAC_BITS_DEF = 13;
   localparam int QUAT_FRAC_BITS_DEF  = 14;
   localparam int CORDIC_STAGES_DEF   = 16;

   localparam int FIELD_W   = 16;
   localparam int WORK_FRAC = 30;
   localparam int XY_W      = 32;   // CORDIC vector, Q30, magnitude below 2^30
   localparam int Z_W       = 34;   // residual angle, Q30
   localparam int PROD_W    = 32;   // triple products and components
   localparam int SQ_W      = 64;   // sum of squares, Q60
   localparam int ROOT_BITS = 32;
   localparam int NORM_W    = 32;
   localparam int REM_W     = 64;

   localparam longint PI_Q32 = 64'sd13493037705;

   // quotient of two positive constants, shift and subtract; elaboration only
   function automatic longint const_quo(input longint num, input longint den);
      longint rem;
      longint quo;
      rem = 0;
      quo = 0;
      for (int b = 62; b >= 0; b--) begin
         rem = (rem <<< 1) | ((num >>> b) & 64'sd1);
         quo = quo <<< 1;
         if (rem >= den) begin
            rem = rem - den;
            quo = quo | 64'sd1;
         end
      end
      return quo;
   endfunction

   // atan(2^-i) in Q30; evaluated at elaboration only
   function automatic longint atan_pow2(input int i);
      longint sum;
      longint term;
      int     e;
      int     k;
      sum = 0;
      if (i == 0) begin
         return (PI_Q32 + 64'sd8) >>> 4;
      end
      for (k = 0; k < 32; k++) begin
         e = i * (2 * k + 1);
         if (e <= 62) begin
            term = const_quo(64'sd1 <<< (62 - e), longint'(2 * k + 1));
            if ((k % 2) == 1) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
      end
      return (sum + (64'sd1 <<< 31)) >>> 32;
   endfunction

   // shift right by WORK_FRAC, round half up
   function automatic logic signed [PROD_W-1:0] rnd_work(input logic signed [63:0] p);
      logic signed [63:0] t;
      t = (p + (64'sd1 <<< (WORK_FRAC - 1))) >>> WORK_FRAC;
      return t[PROD_W-1:0];
   endfunction

endpackage

/* sv/eqc_cordic_cell.sv */
// ----------------------------------------------------------------------------
// eqc_cordic_cell
// One rotation-mode CORDIC micro-rotation, registered.
// ----------------------------------------------------------------------------
module eqc_cordic_cell
   import eqc_pkg::*;
#(
   parameter int STAGE = 0
) (
   input  logic                   clock,
   input  logic                   en,
   input  logic signed [XY_W-1:0] src_x,
   input  logic signed [XY_W-1:0] src_y,
   input  logic signed [Z_W-1:0]  src_z,
   output logic signed [XY_W-1:0] dst_x,
   output logic signed [XY_W-1:0] dst_y,
   output logic signed [Z_W-1:0]  dst_z
);

   localparam logic signed [Z_W-1:0] ATAN = Z_W'(atan_pow2(STAGE));

   logic signed [XY_W-1:0] x_ff, x_in, y_ff, y_in, dx, dy;
   logic signed [Z_W-1:0]  z_ff, z_in;

   assign dx = src_y >>> STAGE;
   assign dy = src_x >>> STAGE;

   always_comb begin
      if (!src_z[Z_W-1]) begin
         x_in = src_x - dx;
         y_in = src_y + dy;
         z_in = src_z - ATAN;
      end else begin
         x_in = src_x + dx;
         y_in = src_y - dy;
         z_in = src_z + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign dst_x = x_ff;
   assign dst_y = y_ff;
   assign dst_z = z_ff;

endmodule

/* sv/eqc_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// eqc_sqrt_cell
// One digit step of the integer square root, registered.
// ----------------------------------------------------------------------------
module eqc_sqrt_cell
   import eqc_pkg::*;
#(
   parameter int BIT_POS = 62
) (
   input  logic              clock,
   input  logic              en,
   input  logic [SQ_W-1:0]   src_v,
   input  logic [SQ_W-1:0]   src_r,
   output logic [SQ_W-1:0]   dst_v,
   output logic [SQ_W-1:0]   dst_r
);

   localparam logic [SQ_W-1:0] BIT_VAL = SQ_W'(1) << BIT_POS;

   logic [SQ_W-1:0] v_ff, v_in, r_ff, r_in, trial;

   assign trial = src_r + BIT_VAL;

   always_comb begin
      if (src_v >= trial) begin
         v_in = src_v - trial;
         r_in = (src_r >> 1) + BIT_VAL;
      end else begin
         v_in = src_v;
         r_in = src_r >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff <= v_in;
         r_ff <= r_in;
      end
   end

   assign dst_v = v_ff;
   assign dst_r = r_ff;

endmodule

/* sv/eqc_div_cell.sv */
// ----------------------------------------------------------------------------
// eqc_div_cell
// One restoring division step: one quotient bit, registered.
// ----------------------------------------------------------------------------
module eqc_div_cell
   import eqc_pkg::*;
#(
   parameter int QB    = 15,
   parameter int SHIFT = 0
) (
   input  logic              clock,
   input  logic              en,
   input  logic [REM_W-1:0]  src_rem,
   input  logic [NORM_W-1:0] src_den,
   input  logic [QB-1:0]     src_quo,
   output logic [REM_W-1:0]  dst_rem,
   output logic [NORM_W-1:0] dst_den,
   output logic [QB-1:0]     dst_quo
);

   logic [REM_W-1:0]  rem_ff, rem_in, sub;
   logic [NORM_W-1:0] den_ff;
   logic [QB-1:0]     quo_ff, quo_in;

   assign sub = REM_W'(src_den) << SHIFT;

   always_comb begin
      if (src_rem >= sub) begin
         rem_in = src_rem - sub;
         quo_in = src_quo | (QB'(1) << SHIFT);
      end else begin
         rem_in = src_rem;
         quo_in = src_quo;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         den_ff <= src_den;
         quo_ff <= quo_in;
      end
   end

   assign dst_rem = rem_ff;
   assign dst_den = den_ff;
   assign dst_quo = quo_ff;

endmodule

/* sv/euler_to_quaternion_unit.sv */
// ----------------------------------------------------------------------------
// euler_to_quaternion_unit
// Roll/pitch/yaw (3-2-1) to normalized unit quaternion, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one angle triple per cycle unless the pipe is held, and returns one
// quaternion per request. Stages, in order: one input register, a row of
// CORDIC cells per angle, two multiply stages for the triple products, a sum,
// square and two-level add, a 32-cell square-root row, a numerator stage, one
// divider cell per quotient bit for each component, and the output register.
// The whole pipe advances together and holds while the output register is
// full and not taken.
// ----------------------------------------------------------------------------
`include "euler_to_quaternion_unit_macros.svh"

module euler_to_quaternion_unit
   import eqc_pkg::*;
#(
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
   parameter int QUAT_FRAC_BITS  = QUAT_FRAC_BITS_DEF,
   parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // roll_angle, pitch_angle, yaw_angle
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // q_scalar, q_x, q_y, q_z
);

   localparam int N     = CORDIC_STAGES;
   localparam int QB    = QUAT_FRAC_BITS + 1;
   localparam int DEPTH = N + 41 + QB;
   localparam int S_NUM = N + 39;
   localparam longint LIM_L =
      (PI_Q32 + (64'sd1 <<< (31 - ANGLE_FRAC_BITS))) >>> (32 - ANGLE_FRAC_BITS);
   localparam logic signed [31:0] ANG_LIM = 32'(LIM_L);
   localparam logic signed [XY_W-1:0] X_START = XY_W'(64'sd1 <<< (WORK_FRAC - 1));
   localparam logic [QB-1:0] ONE_Q = QB'(1) << QUAT_FRAC_BITS;
   localparam logic signed [32:0] ONE_S = 33'(ONE_Q);
   localparam logic signed [32:0] MAX_S = 33'sd32767;
   localparam logic signed [32:0] MIN_S = -33'sd32768;
   localparam logic signed [32:0] BND_S = (ONE_S > MAX_S) ? MAX_S : ONE_S;

   logic             en;
   logic [DEPTH-1:0] vld_ff;

   assign en         = !vld_ff[DEPTH-1] || rsp_tready;
   assign req_tready = en && !reset;
   assign rsp_tvalid = vld_ff[DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[DEPTH-2:0], req_tvalid};
      end
   end

   // clamp to +-pi, then half angle in Q30
   function automatic logic signed [Z_W-1:0] half_angle(input logic [FIELD_W-1:0] raw);
      logic signed [31:0] v;
      v = 32'(signed'(raw));
      if (v > ANG_LIM) begin
         v = ANG_LIM;
      end
      if (v < -ANG_LIM) begin
         v = -ANG_LIM;
      end
      return Z_W'(v) <<< (WORK_FRAC - 1 - ANGLE_FRAC_BITS);
   endfunction

   // ---------------- input register and CORDIC rows
   logic signed [Z_W-1:0]  ang_ff [0:2];
   logic signed [XY_W-1:0] cx [0:2][0:N];
   logic signed [XY_W-1:0] cy [0:2][0:N];
   logic signed [Z_W-1:0]  cz [0:2][0:N];

   always_ff @(posedge clock) begin
      if (en) begin
         ang_ff[0] <= half_angle(req_tdata[15:0]);
         ang_ff[1] <= half_angle(req_tdata[31:16]);
         ang_ff[2] <= half_angle(req_tdata[47:32]);
      end
   end

   for (genvar a = 0; a < 3; a++) begin : g_axis
      assign cx[a][0] = X_START;
      assign cy[a][0] = '0;
      assign cz[a][0] = ang_ff[a];
      for (genvar k = 0; k < N; k++) begin : g_cell
         eqc_cordic_cell #(.STAGE(k)) u_cell (
            .clock (clock),
            .en    (en),
            .src_x (cx[a][k]),
            .src_y (cy[a][k]),
            .src_z (cz[a][k]),
            .dst_x (cx[a][k+1]),
            .dst_y (cy[a][k+1]),
            .dst_z (cz[a][k+1])
         );
      end
   end

   // ---------------- triple products
   logic signed [PROD_W-1:0] cr, sr, cp, sp, cyw, syw;
   logic signed [PROD_W-1:0] cc_ff, ss_ff, sc_ff, cs_ff, cyd_ff, syd_ff;
   logic signed [PROD_W-1:0] t_ff [0:7];
   logic signed [PROD_W-1:0] q_ff [0:3];

   assign cr  = cx[0][N];
   assign sr  = cy[0][N];
   assign cp  = cx[1][N];
   assign sp  = cy[1][N];
   assign cyw = cx[2][N];
   assign syw = cy[2][N];

   always_ff @(posedge clock) begin
      if (en) begin
         cc_ff  <= rnd_work(64'(cr) * 64'(cp));
         ss_ff  <= rnd_work(64'(sr) * 64'(sp));
         sc_ff  <= rnd_work(64'(sr) * 64'(cp));
         cs_ff  <= rnd_work(64'(cr) * 64'(sp));
         cyd_ff <= cyw;
         syd_ff <= syw;
         t_ff[0] <= rnd_work(64'(cc_ff) * 64'(cyd_ff));
         t_ff[1] <= rnd_work(64'(ss_ff) * 64'(syd_ff));
         t_ff[2] <= rnd_work(64'(sc_ff) * 64'(cyd_ff));
         t_ff[3] <= rnd_work(64'(cs_ff) * 64'(syd_ff));
         t_ff[4] <= rnd_work(64'(cs_ff) * 64'(cyd_ff));
         t_ff[5] <= rnd_work(64'(sc_ff) * 64'(syd_ff));
         t_ff[6] <= rnd_work(64'(cc_ff) * 64'(syd_ff));
         t_ff[7] <= rnd_work(64'(ss_ff) * 64'(cyd_ff));
         q_ff[0] <= t_ff[0] + t_ff[1];
         q_ff[1] <= t_ff[2] - t_ff[3];
         q_ff[2] <= t_ff[4] + t_ff[5];
         q_ff[3] <= t_ff[6] - t_ff[7];
      end
   end

   // ---------------- sum of squares
   logic [SQ_W-1:0]          sqr_ff [0:3];
   logic [SQ_W-1:0]          s01_ff, s23_ff, sq_ff;
   logic signed [PROD_W-1:0] qa_ff [0:3];
   logic signed [PROD_W-1:0] qb_ff [0:3];
   logic signed [PROD_W-1:0] qc_ff [0:3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            sqr_ff[i] <= unsigned'(64'(q_ff[i]) * 64'(q_ff[i]));
            qa_ff[i]  <= q_ff[i];
            qb_ff[i]  <= qa_ff[i];
            qc_ff[i]  <= qb_ff[i];
         end
         s01_ff <= sqr_ff[0] + sqr_ff[1];
         s23_ff <= sqr_ff[2] + sqr_ff[3];
         sq_ff  <= s01_ff + s23_ff;
      end
   end

   // ---------------- square-root row, components ride alongside
   logic [SQ_W-1:0]          rv [0:ROOT_BITS];
   logic [SQ_W-1:0]          rr [0:ROOT_BITS];
   logic signed [PROD_W-1:0] qd_ff [0:ROOT_BITS-1][0:3];

   assign rv[0] = sq_ff;
   assign rr[0] = '0;

   for (genvar j = 0; j < ROOT_BITS; j++) begin : g_root
      eqc_sqrt_cell #(.BIT_POS(62 - 2 * j)) u_cell (
         .clock (clock),
         .en    (en),
         .src_v (rv[j]),
         .src_r (rr[j]),
         .dst_v (rv[j+1]),
         .dst_r (rr[j+1])
      );
      always_ff @(posedge clock) begin
         if (en) begin
            for (int i = 0; i < 4; i++) begin
               qd_ff[j][i] <= (j == 0) ? qc_ff[i] : qd_ff[(j == 0) ? 0 : j - 1][i];
            end
         end
      end
   end

   // ---------------- numerators
   logic [NORM_W-1:0] norm, den_ff;
   logic [REM_W-1:0]  num_ff [0:3];
   logic [3:0]        sgn_ff;
   logic              zero_ff;

   assign norm = rr[ROOT_BITS][NORM_W-1:0];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            sgn_ff[i] <= qd_ff[ROOT_BITS-1][i][PROD_W-1];
            num_ff[i] <= (REM_W'(unsigned'(qd_ff[ROOT_BITS-1][i][PROD_W-1]
                                  ? -33'(qd_ff[ROOT_BITS-1][i])
                                  : 33'(qd_ff[ROOT_BITS-1][i]))) << QUAT_FRAC_BITS)
                          + REM_W'(norm >> 1);
         end
         den_ff  <= norm;
         zero_ff <= (norm == '0);
      end
   end

   // ---------------- divider rows, one per component
   logic [REM_W-1:0]  dr [0:3][0:QB];
   logic [NORM_W-1:0] dd [0:3][0:QB];
   logic [QB-1:0]     dq [0:3][0:QB];
   logic [3:0]        sgd_ff [0:QB-1];
   logic              zd_ff  [0:QB-1];

   for (genvar i = 0; i < 4; i++) begin : g_lane
      assign dr[i][0] = num_ff[i];
      assign dd[i][0] = den_ff;
      assign dq[i][0] = '0;
      for (genvar j = 0; j < QB; j++) begin : g_cell
         eqc_div_cell #(.QB(QB), .SHIFT(QB - 1 - j)) u_cell (
            .clock   (clock),
            .en      (en),
            .src_rem (dr[i][j]),
            .src_den (dd[i][j]),
            .src_quo (dq[i][j]),
            .dst_rem (dr[i][j+1]),
            .dst_den (dd[i][j+1]),
            .dst_quo (dq[i][j+1])
         );
      end
   end

   for (genvar j = 0; j < QB; j++) begin : g_side
      always_ff @(posedge clock) begin
         if (en) begin
            sgd_ff[j] <= (j == 0) ? sgn_ff  : sgd_ff[(j == 0) ? 0 : j - 1];
            zd_ff[j]  <= (j == 0) ? zero_ff : zd_ff[(j == 0) ? 0 : j - 1];
         end
      end
   end

   // ---------------- output register
   function automatic logic [FIELD_W-1:0] to_field(input logic [QB-1:0] quo,
                                                     input logic        neg);
      logic [QB-1:0]      mag;
      logic signed [32:0] v;
      mag = (quo > ONE_Q) ? ONE_Q : quo;
      v   = neg ? -33'(mag) : 33'(mag);
      if (v > MAX_S) begin
         v = MAX_S;
      end
      if (v < MIN_S) begin
         v = MIN_S;
      end
      return v[FIELD_W-1:0];
   endfunction

   logic [FIELD_W-1:0] out_ff [0:3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            if (zd_ff[QB-1]) begin
               out_ff[i] <= (i == 0) ? BND_S[FIELD_W-1:0] : '0;
            end else begin
               out_ff[i] <= to_field(dq[i][QB], sgd_ff[QB-1][i]);
            end
         end
      end
   end

   assign rsp_tdata = {out_ff[3], out_ff[2], out_ff[1], out_ff[0]};

   // ---------------- checks
   `EQC_ASSERT_ALWAYS(a_stall_blocks_input, (rsp_tvalid && !rsp_tready) |-> !req_tready, "input taken while output stalled")
   `EQC_ASSERT(a_accept_enters_pipe, (req_tvalid && req_tready) |=> vld_ff[0], "accepted request lost at pipe entry")
   `EQC_ASSERT(a_norm_nonzero, vld_ff[S_NUM] |-> !zero_ff, "zero quaternion norm")
   `EQC_ASSERT(a_scalar_bound, rsp_tvalid |-> (33'(signed'(out_ff[0])) <= BND_S && 33'(signed'(out_ff[0])) >= -BND_S - 33'sd1), "scalar part out of range")

endmodule
